@@ rtl/dlt_pkg.sv @@
package dlt_pkg;

  // operation codes
  localparam logic [2:0] OP_REGISTER = 3'd0;
  localparam logic [2:0] OP_TOUCH    = 3'd1;
  localparam logic [2:0] OP_REMOVE   = 3'd2;
  localparam logic [2:0] OP_SWEEP    = 3'd3;
  localparam logic [2:0] OP_LOOKUP   = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  localparam int CNT_W = 7;

  // one table entry as stored in memory
  typedef struct packed {
    logic [31:0] device_id;
    logic [15:0] handle;
    logic [63:0] beat_ms;
  } entry_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_EVICT = 3'b100
  } state_t;

endpackage

@@ rtl/dlt_ram.sv @@
module dlt_ram #(
  parameter int WIDTH = 112,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/device_liveness_table_top.sv @@
// lookup, touch, register and remove scan the table until a match or the last slot; the entry
// memory is scanned one slot per cycle through its single read port
// sweep: a first scan counts evictions, then a second scan emits one result per
// eviction; one item at a time
// results are strobed for one cycle and cannot be stalled by the receiver
// synchronous reset clears all valid bits, occupancy, and sets timeout_ms to 30000
module device_liveness_table_top #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  opcode,
  input  logic [31:0] device_id,
  input  logic [15:0] handle,
  input  logic [63:0] now_ms,
  input  logic [6:0]  report_limit,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  output logic        strobe,
  output logic [1:0]  status,
  output logic [15:0] out_handle,
  output logic        close_old,
  output logic [63:0] last_seen_ms,
  output logic        reported,
  output logic [6:0]  evicted_count,
  output logic [6:0]  occupancy,
  output logic        last
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);
  localparam int CW = dlt_pkg::CNT_W;

  dlt_pkg::state_t state;
  logic [31:0] timeout_ms;
  logic [TABLE_ENTRIES-1:0] valid;
  logic [CW-1:0] used;

  // latched item
  logic [2:0]  op_q;
  logic [31:0] id_q;
  logic [15:0] h_q;
  logic [63:0] now_q;
  logic [6:0]  limit_q;

  // scan pipeline
  logic [IW-1:0] rd_idx;
  logic          rd_done;
  logic [IW-1:0] chk_idx;
  logic          chk_on;
  logic          free_found;
  logic [IW-1:0] free_idx;
  logic [CW-1:0] n_q;
  logic [CW-1:0] k_q;

  // memory ports
  logic               ram_we;
  logic [IW-1:0]      ram_waddr;
  dlt_pkg::entry_t    ram_wdata;
  dlt_pkg::entry_t    rdata;

  dlt_ram #(
    .WIDTH($bits(dlt_pkg::entry_t)),
    .DEPTH(TABLE_ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(rd_idx),
    .rdata(rdata)
  );

  assign busy      = (state != dlt_pkg::S_IDLE);
  assign cfg_ready = 1'b1;

  // compare results on the slot read last cycle
  logic          chk_valid;
  logic          id_hit;
  logic          h_hit;
  logic          old_hit;
  logic          chk_last;
  logic [63:0]   age;
  logic          free_any;
  logic [IW-1:0] free_pick;
  logic [CW-1:0] n_total;

  always_comb begin
    chk_valid = chk_on && valid[chk_idx];
    id_hit    = chk_valid && (rdata.device_id == id_q);
    h_hit     = chk_valid && (rdata.handle == h_q);
    age       = now_q - rdata.beat_ms;
    old_hit   = chk_valid && (age > {32'd0, timeout_ms});
    chk_last  = chk_on && (chk_idx == LAST_IDX);
    free_any  = free_found || (chk_on && !valid[chk_idx]);
    free_pick = free_found ? free_idx : chk_idx;
    n_total   = n_q + CW'(old_hit);
  end

  // entry write for register and touch
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = chk_idx;
    ram_wdata = '{device_id: id_q, handle: h_q, beat_ms: now_q};
    if (state == dlt_pkg::S_SCAN) begin
      if (op_q == dlt_pkg::OP_REGISTER) begin
        if (id_hit) begin
          ram_we = 1'b1;
        end else if (chk_last && free_any) begin
          ram_we    = 1'b1;
          ram_waddr = free_pick;
        end
      end else if (op_q == dlt_pkg::OP_TOUCH && id_hit) begin
        ram_we    = 1'b1;
        ram_wdata = '{device_id: rdata.device_id, handle: rdata.handle, beat_ms: now_q};
      end
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms <= 32'd30000;
    end else if (cfg_valid && cfg_ready) begin
      timeout_ms <= cfg_data;
    end
  end

  // sequencer, table state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= dlt_pkg::S_IDLE;
      valid      <= '0;
      used       <= '0;
      strobe     <= 1'b0;
      chk_on     <= 1'b0;
      rd_done    <= 1'b0;
      rd_idx     <= '0;
      free_found <= 1'b0;
    end else begin
      strobe        <= 1'b0;
      status        <= dlt_pkg::ST_OK;
      out_handle    <= '0;
      close_old     <= 1'b0;
      last_seen_ms  <= '0;
      reported      <= 1'b0;
      evicted_count <= '0;
      occupancy     <= used;
      last          <= 1'b1;

      // address issue, one slot per cycle
      if (state != dlt_pkg::S_IDLE) begin
        chk_on  <= !rd_done;
        chk_idx <= rd_idx;
        if (!rd_done) begin
          if (rd_idx == LAST_IDX) begin
            rd_done <= 1'b1;
          end else begin
            rd_idx <= rd_idx + 1'b1;
          end
        end
      end

      unique case (state)
        dlt_pkg::S_IDLE: begin
          if (start) begin
            op_q       <= opcode;
            id_q       <= device_id;
            h_q        <= handle;
            now_q      <= now_ms;
            limit_q    <= report_limit;
            rd_idx     <= '0;
            rd_done    <= 1'b0;
            chk_on     <= 1'b0;
            free_found <= 1'b0;
            n_q        <= '0;
            k_q        <= '0;
            if (opcode > dlt_pkg::OP_LOOKUP) begin
              strobe <= 1'b1;
              status <= dlt_pkg::ST_NOTFOUND;
            end else begin
              state <= dlt_pkg::S_SCAN;
            end
          end
        end

        dlt_pkg::S_SCAN: begin
          if (chk_on && !valid[chk_idx] && !free_found) begin
            free_found <= 1'b1;
            free_idx   <= chk_idx;
          end
          unique case (op_q)
            dlt_pkg::OP_REGISTER: begin
              if (id_hit) begin
                strobe <= 1'b1;
                state  <= dlt_pkg::S_IDLE;
                if (rdata.handle != h_q) begin
                  close_old  <= 1'b1;
                  out_handle <= rdata.handle;
                end
              end else if (chk_last) begin
                strobe <= 1'b1;
                state  <= dlt_pkg::S_IDLE;
                if (free_any) begin
                  valid[free_pick] <= 1'b1;
                  used             <= used + 1'b1;
                  occupancy        <= used + 1'b1;
                end else begin
                  status <= dlt_pkg::ST_FULL;
                end
              end
            end
            dlt_pkg::OP_TOUCH, dlt_pkg::OP_LOOKUP: begin
              if (id_hit) begin
                strobe <= 1'b1;
                state  <= dlt_pkg::S_IDLE;
                if (op_q == dlt_pkg::OP_LOOKUP) begin
                  out_handle   <= rdata.handle;
                  last_seen_ms <= rdata.beat_ms;
                end
              end else if (chk_last) begin
                strobe <= 1'b1;
                status <= dlt_pkg::ST_NOTFOUND;
                state  <= dlt_pkg::S_IDLE;
              end
            end
            dlt_pkg::OP_REMOVE: begin
              if (h_hit) begin
                valid[chk_idx] <= 1'b0;
                used           <= used - 1'b1;
                occupancy      <= used - 1'b1;
                strobe         <= 1'b1;
                state          <= dlt_pkg::S_IDLE;
              end else if (chk_last) begin
                strobe <= 1'b1;
                status <= dlt_pkg::ST_NOTFOUND;
                state  <= dlt_pkg::S_IDLE;
              end
            end
            default: begin
              // sweep, first pass counts the evictions
              n_q <= n_total;
              if (chk_last) begin
                if (n_total == '0) begin
                  strobe <= 1'b1;
                  status <= dlt_pkg::ST_NOTFOUND;
                  state  <= dlt_pkg::S_IDLE;
                end else begin
                  used    <= used - n_total;
                  state   <= dlt_pkg::S_EVICT;
                  rd_idx  <= '0;
                  rd_done <= 1'b0;
                  chk_on  <= 1'b0;
                end
              end
            end
          endcase
        end

        dlt_pkg::S_EVICT: begin
          // second pass evicts and reports one transfer per eviction
          if (old_hit) begin
            valid[chk_idx] <= 1'b0;
            strobe         <= 1'b1;
            out_handle     <= rdata.handle;
            reported       <= (CW'(k_q) < limit_q);
            evicted_count  <= k_q + 1'b1;
            last           <= ((k_q + 1'b1) == n_q);
            k_q            <= k_q + 1'b1;
            if ((k_q + 1'b1) == n_q) begin
              state <= dlt_pkg::S_IDLE;
            end
          end
        end

        default: begin
          state <= dlt_pkg::S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !ram_we) else $error("table written while idle");

  a_occ_match: assert property (@(posedge clk) disable iff (rst)
    (!busy && !$past(rst)) |-> (32'(used) == $countones(valid)))
    else $error("occupancy disagrees with valid bits");

  a_close_ok: assert property (@(posedge clk) disable iff (rst)
    (strobe && close_old) |-> (status == dlt_pkg::ST_OK))
    else $error("close_old with failing status");

  a_evict_count: assert property (@(posedge clk) disable iff (rst)
    (strobe && reported) |-> (evicted_count != 7'd0))
    else $error("reported eviction with zero count");
`endif

endmodule

@@ dv/dlt_checker.sv @@
module dlt_checker #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [2:0]  opcode,
  input  logic [31:0] device_id,
  input  logic [15:0] handle,
  input  logic [63:0] now_ms,
  input  logic [6:0]  report_limit,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  logic        strobe,
  input  logic [1:0]  status,
  input  logic [15:0] out_handle,
  input  logic        close_old,
  input  logic [63:0] last_seen_ms,
  input  logic        reported,
  input  logic [6:0]  evicted_count,
  input  logic [6:0]  occupancy,
  input  logic        last,
  output int          fail_count,
  output int          pending,
  output int          checked_count,
  output int          eviction_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] out_handle;
    logic        close_old;
    logic [63:0] last_seen_ms;
    logic        reported;
    logic [6:0]  evicted_count;
    logic [6:0]  occupancy;
    logic        last;
  } liveness_result_t;

  // mirror of the device table
  logic            slot_used [TABLE_ENTRIES];
  dlt_pkg::entry_t slot      [TABLE_ENTRIES];
  logic [6:0]      used_slots;
  logic [31:0]     timeout_limit;

  liveness_result_t expected_results[$];

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, field, got, want);
    fail_count++;
  endtask

  function automatic int find_device(logic [31:0] id);
    for (int i = 0; i < TABLE_ENTRIES; i++)
      if (slot_used[i] && slot[i].device_id == id) return i;
    return -1;
  endfunction

  function automatic void add_result(logic [1:0] st, logic [15:0] h, logic cl,
                                     logic [63:0] seen, logic rep, logic [6:0] cnt,
                                     logic lst);
    liveness_result_t r;
    r.status = st;
    r.out_handle = h;
    r.close_old = cl;
    r.last_seen_ms = seen;
    r.reported = rep;
    r.evicted_count = cnt;
    r.occupancy = used_slots;
    r.last = lst;
    expected_results.push_back(r);
  endfunction

  // work out the results of one accepted command
  function automatic void predict_command(logic [2:0] op, logic [31:0] id, logic [15:0] h,
                                          logic [63:0] now, logic [6:0] lim);
    int s;
    int n;
    logic [15:0] gone [$];
    logic [15:0] old_h;
    logic replaced;
    s = -1;
    old_h = '0;
    replaced = 1'b0;
    case (op)
      dlt_pkg::OP_REGISTER: begin
        s = find_device(id);
        if (s < 0) begin
          for (int i = 0; i < TABLE_ENTRIES; i++)
            if (!slot_used[i]) begin
              s = i;
              break;
            end
          if (s < 0) begin
            add_result(dlt_pkg::ST_FULL, '0, 1'b0, '0, 1'b0, '0, 1'b1);
            return;
          end
          slot_used[s] = 1'b1;
          used_slots++;
        end else if (slot[s].handle != h) begin
          replaced = 1'b1;
          old_h = slot[s].handle;
        end
        slot[s].device_id = id;
        slot[s].handle = h;
        slot[s].beat_ms = now;
        add_result(dlt_pkg::ST_OK, old_h, replaced, '0, 1'b0, '0, 1'b1);
      end
      dlt_pkg::OP_TOUCH: begin
        s = find_device(id);
        if (s >= 0) slot[s].beat_ms = now;
        add_result(s >= 0 ? dlt_pkg::ST_OK : dlt_pkg::ST_NOTFOUND,
                   '0, 1'b0, '0, 1'b0, '0, 1'b1);
      end
      dlt_pkg::OP_REMOVE: begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
          if (slot_used[i] && slot[i].handle == h) begin
            s = i;
            break;
          end
        if (s >= 0) begin
          slot_used[s] = 1'b0;
          used_slots--;
        end
        add_result(s >= 0 ? dlt_pkg::ST_OK : dlt_pkg::ST_NOTFOUND,
                   '0, 1'b0, '0, 1'b0, '0, 1'b1);
      end
      dlt_pkg::OP_SWEEP: begin
        // evict first, occupancy on every result is the final one
        for (int i = 0; i < TABLE_ENTRIES; i++)
          if (slot_used[i] && (now - slot[i].beat_ms) > {32'd0, timeout_limit}) begin
            gone.push_back(slot[i].handle);
            slot_used[i] = 1'b0;
            used_slots--;
          end
        n = gone.size();
        if (n == 0) add_result(dlt_pkg::ST_NOTFOUND, '0, 1'b0, '0, 1'b0, '0, 1'b1);
        for (int k = 0; k < n; k++)
          add_result(dlt_pkg::ST_OK, gone[k], 1'b0, '0, k < int'(lim), 7'(k + 1),
                     k == n - 1);
      end
      dlt_pkg::OP_LOOKUP: begin
        s = find_device(id);
        if (s >= 0)
          add_result(dlt_pkg::ST_OK, slot[s].handle, 1'b0, slot[s].beat_ms, 1'b0, '0,
                     1'b1);
        else add_result(dlt_pkg::ST_NOTFOUND, '0, 1'b0, '0, 1'b0, '0, 1'b1);
      end
      default: begin
        add_result(dlt_pkg::ST_NOTFOUND, '0, 1'b0, '0, 1'b0, '0, 1'b1);
      end
    endcase
  endfunction

  // watch config, results and commands
  always @(posedge clk) begin
    liveness_result_t want;
    if (rst) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) slot_used[i] = 1'b0;
      used_slots = '0;
      timeout_limit = 32'd30000;
      expected_results.delete();
      fail_count = 0;
      checked_count = 0;
      eviction_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) timeout_limit = cfg_data;
      if (strobe) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", 64'd1, 64'd0);
        end else begin
          want = expected_results.pop_front();
          checked_count++;
          if (status == dlt_pkg::ST_OK && last_seen_ms == '0 && evicted_count != '0)
            eviction_count++;
          if (status !== want.status) report_mismatch("status", status, want.status);
          if (out_handle !== want.out_handle)
            report_mismatch("out_handle", out_handle, want.out_handle);
          if (close_old !== want.close_old)
            report_mismatch("close_old", close_old, want.close_old);
          if (last_seen_ms !== want.last_seen_ms)
            report_mismatch("last_seen_ms", last_seen_ms, want.last_seen_ms);
          if (reported !== want.reported)
            report_mismatch("reported", reported, want.reported);
          if (evicted_count !== want.evicted_count)
            report_mismatch("evicted_count", evicted_count, want.evicted_count);
          if (occupancy !== want.occupancy)
            report_mismatch("occupancy", occupancy, want.occupancy);
          if (last !== want.last) report_mismatch("last", last, want.last);
        end
      end
      if (start && !busy) predict_command(opcode, device_id, handle, now_ms, report_limit);
    end
    pending = expected_results.size();
  end

endmodule

@@ dv/tb_device_liveness_table_top.sv @@
module tb_device_liveness_table_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES = 64;
  localparam int SETTLE_CYCLES = 2 * ENTRIES + 10;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  opcode = dlt_pkg::OP_LOOKUP;
  logic [31:0] device_id = '0;
  logic [15:0] handle = '0;
  logic [63:0] now_ms = '0;
  logic [6:0]  report_limit = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;
  logic        strobe;
  logic [1:0]  status;
  logic [15:0] out_handle;
  logic        close_old;
  logic [63:0] last_seen_ms;
  logic        reported;
  logic [6:0]  evicted_count;
  logic [6:0]  occupancy;
  logic        last;

  int fail_count, pending, checked_count, eviction_count;
  int commands_sent = 0;
  int sweeps_sent = 0;
  bit no_gaps = 1'b0;

  logic [31:0] id_pool     [80];
  logic [15:0] handle_pool [100];
  logic [63:0] clock_ms = '0;
  logic [31:0] cur_timeout = 32'd30000;

  device_liveness_table_top #(.TABLE_ENTRIES(ENTRIES)) DUT (.*);

  dlt_checker #(.TABLE_ENTRIES(ENTRIES)) u_checker (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #4ms;
    $display("tb: failure");
    $finish;
  end

  // one command transfer; start is left high so back-to-back items need no toggle
  task automatic send_command(logic [2:0] op, logic [31:0] id, logic [15:0] h,
                              logic [63:0] now, logic [6:0] lim);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    opcode <= op;
    device_id <= id;
    handle <= h;
    now_ms <= now;
    report_limit <= lim;
    do @(posedge clk); while (busy);
    commands_sent++;
    if (op == dlt_pkg::OP_SWEEP) sweeps_sent++;
  endtask

  // wait until the block is idle and every expected result has come
  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (busy || pending != 0) @(posedge clk);
  endtask

  // timeout register write while the table is quiet
  task automatic write_timeout(logic [31:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_timeout = value;
  endtask

  function automatic logic [31:0] pick_id();
    return ($urandom_range(0, 3) != 0) ? id_pool[$urandom_range(0, 79)] : $urandom();
  endfunction

  function automatic logic [15:0] pick_handle();
    return ($urandom_range(0, 4) != 0) ? handle_pool[$urandom_range(0, 99)]
                                       : 16'($urandom());
  endfunction

  // move the shared clock forward, now and then by a huge or wrapping jump or to a random value
  function automatic void advance_clock();
    case ($urandom_range(0, 9))
      0:       clock_ms = {$urandom(), $urandom()};
      1, 2:    clock_ms += {32'd0, cur_timeout} + 64'($urandom_range(0, 3));
      3:       clock_ms += {$urandom_range(0, 3), $urandom()};
      default: clock_ms += 64'($urandom_range(0, 2000));
    endcase
  endfunction

  task automatic random_command();
    logic [63:0] t;
    int pick;
    advance_clock();
    t = ($urandom_range(0, 9) == 0) ? {$urandom(), $urandom()} : clock_ms;
    pick = $urandom_range(0, 99);
    if (pick < 35)
      send_command(dlt_pkg::OP_REGISTER, pick_id(), pick_handle(), t, 7'($urandom()));
    else if (pick < 50)
      send_command(dlt_pkg::OP_TOUCH, pick_id(), pick_handle(), t, 7'($urandom()));
    else if (pick < 62)
      send_command(dlt_pkg::OP_REMOVE, pick_id(), pick_handle(), t, 7'($urandom()));
    else if (pick < 74)
      send_command(dlt_pkg::OP_SWEEP, pick_id(), pick_handle(), t,
                   7'($urandom_range(0, 64)));
    else if (pick < 96)
      send_command(dlt_pkg::OP_LOOKUP, pick_id(), pick_handle(), t, 7'($urandom()));
    else send_command(3'($urandom_range(5, 7)), $urandom(), 16'($urandom()), t, 7'($urandom()));
  endtask

  initial begin
    id_pool[0] = 32'h0;
    id_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 80; i++) id_pool[i] = $urandom();
    handle_pool[0] = 16'h0;
    handle_pool[1] = 16'hFFFF;
    for (int i = 2; i < 100; i++) handle_pool[i] = 16'($urandom());

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes and every special case, reset timeout
    send_command(dlt_pkg::OP_REGISTER, 32'h0, 16'h0, 64'h0, 7'd0);
    send_command(dlt_pkg::OP_REGISTER, 32'hFFFF_FFFF, 16'hFFFF, '1, 7'd127);
    send_command(dlt_pkg::OP_REGISTER, 32'h0, 16'h0, 64'd5, 7'd0);
    send_command(dlt_pkg::OP_REGISTER, 32'h0, 16'h0005, 64'd6, 7'd0);
    send_command(dlt_pkg::OP_TOUCH, 32'h0, 16'h0, 64'd10, 7'd0);
    send_command(dlt_pkg::OP_TOUCH, 32'h1234_5678, 16'h0, 64'd11, 7'd0);
    send_command(dlt_pkg::OP_LOOKUP, 32'h0, 16'h0, 64'h0, 7'd0);
    send_command(dlt_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 16'h0, 64'h0, 7'd0);
    send_command(dlt_pkg::OP_LOOKUP, 32'h8765_4321, 16'h0, 64'h0, 7'd0);
    send_command(dlt_pkg::OP_SWEEP, 32'h0, 16'h0, 64'd20, 7'd64);
    send_command(dlt_pkg::OP_REMOVE, 32'h0, 16'h0005, 64'h0, 7'd0);
    send_command(dlt_pkg::OP_REMOVE, 32'h0, 16'h1234, 64'h0, 7'd0);
    send_command(dlt_pkg::OP_REGISTER, 32'h55, 16'h0055, 64'd100, 7'd0);
    send_command(dlt_pkg::OP_SWEEP, 32'h0, 16'h0, 64'h8000_0000_0000_0000, 7'd1);
    send_command(3'd5, 32'h0, 16'h0, 64'h0, 7'd0);
    send_command(3'd6, '1, '1, '1, 7'd127);
    send_command(3'd7, 32'h0, 16'h0, 64'h0, 7'd0);

    // fill the table past full, then sweep it all at the widest limit
    write_timeout(32'd0);
    no_gaps = 1'b1;
    for (int i = 0; i <= ENTRIES; i++)
      send_command(dlt_pkg::OP_REGISTER, 32'h100 + i, 16'(i + 1), 64'd50, 7'd0);
    no_gaps = 1'b0;
    send_command(dlt_pkg::OP_SWEEP, 32'h0, 16'h0, 64'd51, 7'd127);
    send_command(dlt_pkg::OP_SWEEP, 32'h0, 16'h0, 64'd52, 7'd0);

    // random phases over several timeouts, extremes included
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_timeout(32'd0);
        1: write_timeout(32'hFFFF_FFFF);
        2: write_timeout(32'd1000);
        3: write_timeout($urandom_range(1, 100000));
        4: write_timeout($urandom());
        default: write_timeout(32'd30000);
      endcase
      no_gaps = (phase == 2);
      for (int n = 0; n < 65; n++) begin
        if (phase == 3 && n == 30) drain();
        random_command();
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("tb: %0d commands (%0d sweeps), %0d results checked, %0d evictions",
             commands_sent, sweeps_sent, checked_count, eviction_count);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
